[design/brg_pkg.sv]
`default_nettype none

package brg_pkg;

	localparam int LEVEL_BITS_DEF = 20;
	localparam int MAX_STEPS_DEF = 20;

	// Field widths fixed by the interface
	localparam int PCT_W = 16;
	localparam int STEPS_W = 5;
	localparam int CFG_IDX_W = 8;

	// Percent clamp in Q8.8: 5 % .. 100 %
	localparam int PCT_MIN = 1280;
	localparam int PCT_MAX = 25600;
	localparam int PCT_Q_W = 15;
	// 100 % in Q8.8 is 25 * 1024: drop the low 10 bits, then divide by 25
	localparam int PCT_FRAC_SHIFT = 10;
	localparam int PCT_DIV = 25;

	localparam int STEPS_RESET = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENABLE = 8'd2;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_RCP,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_START,
		B_DIV,
		B_STEP
	} back_state_t;

	// Command handed from front to back
	typedef struct packed {
		logic [STEPS_W-1:0] steps;
	} cmd_ctl_t;

endpackage

`default_nettype wire

[design/brg_fifo.sv]
`default_nettype none

module brg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

[design/brg_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle
module brg_div #(
	parameter int DIVIDEND_W = 27,
	parameter int DIVISOR_W = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic      [DIVIDEND_W-1:0] quot,
	output logic      [DIVISOR_W-1:0]  rem
);
	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] q_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  d_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    trial_sub;
	logic                  fit;

	assign trial     = {rem_q, q_q[DIVIDEND_W-1]};
	assign trial_sub = trial - {1'b0, d_q};
	assign fit       = (trial >= {1'b0, d_q});

	assign done = done_q;
	assign quot = q_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[DIVIDEND_W-2:0], fit};
			rem_q <= fit ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

endmodule

`default_nettype wire

[design/brg_front.sv]
`default_nettype none

// Clamps a request's percent and steps, works out the target and queues a command if the level moves.
module brg_front #(
	parameter int MAX_STEPS = brg_pkg::MAX_STEPS_DEF,
	parameter int LEVEL_BITS = brg_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic signed [brg_pkg::PCT_W-1:0]  requested_percent,
	input  wire logic        [LEVEL_BITS-1:0]      current_level,
	input  wire logic        [LEVEL_BITS-1:0]      full_scale,
	input  wire logic        [brg_pkg::STEPS_W-1:0] num_steps,
	input  wire logic                              ramp_enable,
	output logic                                   cmd_push,
	input  wire logic                              cmd_full,
	output brg_pkg::cmd_ctl_t                      cmd_ctl,
	output logic             [LEVEL_BITS-1:0]      cmd_target,
	output logic             [LEVEL_BITS-1:0]      cmd_cur
);
	import brg_pkg::*;

	localparam int PROD_W = LEVEL_BITS + PCT_Q_W;
	localparam int Z_W = PROD_W - PCT_FRAC_SHIFT;
	// the scaled product stays below 25 * 2^LEVEL_BITS, so a rounded-up
	// reciprocal with this shift gives the exact floor for every input
	localparam int RCP_SH = LEVEL_BITS + 10;
	localparam int RCP_W = RCP_SH - 4;
	localparam int RCP_P_W = Z_W + RCP_W;
	localparam longint RCP_FULL =
		((longint'(1) << RCP_SH) + longint'(PCT_DIV - 1)) / longint'(PCT_DIV);
	localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP_FULL);

	front_state_t            state_q;
	front_state_t            state_d;
	logic [PCT_Q_W-1:0]      pct_c;
	logic [STEPS_W-1:0]      steps_c;
	logic                    accept;
	logic [PCT_Q_W-1:0]      pct_q;
	logic [LEVEL_BITS-1:0]   maxb_q;
	logic [LEVEL_BITS-1:0]   cur_q;
	logic [STEPS_W-1:0]      steps_q;
	logic [PROD_W-1:0]       prod_q;
	logic [RCP_P_W-1:0]      rcp_prod;
	logic [LEVEL_BITS-1:0]   target_q;

	always_comb begin
		if (requested_percent > PCT_MAX) begin
			pct_c = PCT_Q_W'(PCT_MAX);
		end else if (requested_percent < PCT_MIN) begin
			pct_c = PCT_Q_W'(PCT_MIN);
		end else begin
			pct_c = requested_percent[PCT_Q_W-1:0];
		end
	end

	// A jump is a ramp of one step
	always_comb begin
		if (!ramp_enable) begin
			steps_c = STEPS_W'(1);
		end else if (int'(num_steps) > MAX_STEPS) begin
			steps_c = STEPS_W'(MAX_STEPS);
		end else begin
			steps_c = num_steps;
		end
	end

	always_comb begin
		state_d   = state_q;
		full      = 1'b1;
		accept    = 1'b0;
		cmd_push  = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				full = 1'b0;
				// drop requests while the panel scale is unset
				if (push && full_scale != '0) begin
					accept  = 1'b1;
					state_d = F_MUL;
				end
			end
			F_MUL: begin
				state_d = F_RCP;
			end
			F_RCP: begin
				state_d = F_PUSH;
			end
			F_PUSH: begin
				if (target_q == cur_q) begin
					state_d = F_IDLE;
				end else if (!cmd_full) begin
					cmd_push = 1'b1;
					state_d  = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// floor(x / 25600) = floor(floor(x / 1024) / 25), the last step by reciprocal
	assign rcp_prod = RCP_P_W'(prod_q[PROD_W-1:PCT_FRAC_SHIFT]) * RCP_P_W'(RCP_M);

	always_ff @(posedge clk) begin
		if (accept) begin
			pct_q   <= pct_c;
			maxb_q  <= full_scale;
			cur_q   <= current_level;
			steps_q <= steps_c;
		end
		if (state_q == F_MUL) begin
			prod_q <= PROD_W'(maxb_q) * PROD_W'(pct_q);
		end
		if (state_q == F_RCP) begin
			target_q <= rcp_prod[RCP_SH +: LEVEL_BITS];
		end
	end

	assign cmd_ctl.steps = steps_q;
	assign cmd_target    = target_q;
	assign cmd_cur       = cur_q;

endmodule

`default_nettype wire

[design/brg_back.sv]
`default_nettype none

// Walks from current level to target, one step a cycle unless out_full.
module brg_back #(
	parameter int LEVEL_BITS = brg_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_empty,
	output logic                       cmd_pop,
	input  wire brg_pkg::cmd_ctl_t     cmd_ctl,
	input  wire logic [LEVEL_BITS-1:0] cmd_target,
	input  wire logic [LEVEL_BITS-1:0] cmd_cur,
	output logic                       out_push,
	input  wire logic                  out_full,
	output logic      [LEVEL_BITS-1:0] out_level,
	output logic                       out_last
);
	import brg_pkg::*;

	back_state_t            state_q;
	back_state_t            state_d;
	logic [LEVEL_BITS-1:0]  target_q;
	logic [LEVEL_BITS-1:0]  cur_q;
	logic [STEPS_W-1:0]     n_q;
	logic [STEPS_W-1:0]     k_q;
	logic [LEVEL_BITS-1:0]  qd_q;
	logic [STEPS_W-1:0]     rd_q;
	logic [LEVEL_BITS-1:0]  acc_q;
	logic [STEPS_W-1:0]     accr_q;
	logic [LEVEL_BITS-1:0]  prev_q;
	logic                   down;
	logic [LEVEL_BITS-1:0]  absdiff;
	logic                   div_start;
	logic                   div_done;
	logic [LEVEL_BITS-1:0]  div_quot;
	logic [STEPS_W-1:0]     div_rem;
	logic [STEPS_W:0]       rsum;
	logic                   carry;
	logic [STEPS_W-1:0]     accr_next;
	logic [LEVEL_BITS-1:0]  acc_next;
	logic [LEVEL_BITS-1:0]  step_level;
	logic                   is_last;
	logic                   emit;
	logic                   advance;

	assign down    = (target_q < cur_q);
	assign absdiff = down ? (cur_q - target_q) : (target_q - cur_q);

	// |diff|*k / n kept as quotient and remainder, advanced by |diff| / n each step
	assign rsum       = {1'b0, accr_q} + {1'b0, rd_q};
	assign carry      = (rsum >= {1'b0, n_q});
	assign accr_next  = carry ? STEPS_W'(rsum - {1'b0, n_q}) : rsum[STEPS_W-1:0];
	assign acc_next   = acc_q + qd_q + LEVEL_BITS'(carry);
	assign step_level = down ? (cur_q - acc_next) : (cur_q + acc_next);
	assign is_last    = (k_q == n_q);
	assign emit       = is_last || (step_level != prev_q);

	assign out_level = step_level;
	assign out_last  = is_last;

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		div_start = 1'b0;
		out_push  = 1'b0;
		advance   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					state_d = B_START;
				end
			end
			B_START: begin
				div_start = 1'b1;
				state_d   = B_DIV;
			end
			B_DIV: begin
				if (div_done) begin
					state_d = B_STEP;
				end
			end
			B_STEP: begin
				// drop a step that repeats the level before it
				if (!emit || !out_full) begin
					advance  = 1'b1;
					out_push = emit;
					if (is_last) begin
						state_d = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_DIV && div_done) begin
				k_q <= STEPS_W'(1);
			end else if (advance) begin
				k_q <= k_q + STEPS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			target_q <= cmd_target;
			cur_q    <= cmd_cur;
			n_q      <= cmd_ctl.steps;
		end
		if (state_q == B_DIV && div_done) begin
			qd_q   <= div_quot;
			rd_q   <= div_rem;
			acc_q  <= '0;
			accr_q <= '0;
			prev_q <= cur_q;
		end else if (advance) begin
			acc_q  <= acc_next;
			accr_q <= accr_next;
			prev_q <= step_level;
		end
	end

	brg_div #(
		.DIVIDEND_W(LEVEL_BITS),
		.DIVISOR_W (STEPS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(absdiff),
		.divisor (n_q),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

`ifndef ASSERT_OFF
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("step pushed into a full result queue");

	a_last_is_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_last) |-> (out_level == target_q))
		else $error("final step differs from the target level");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == B_DIV))
		else $error("divider finished outside the divide state");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_STEP) |-> (acc_next <= absdiff))
		else $error("step offset passed the full distance");
`endif

endmodule

`default_nettype wire

[design/brightness_ramp_generator.sv]
// An accepted request passes the front (scale multiply, reciprocal multiply, hand-off),
// then the back (load, serial divide) before its first level. Each end takes one request
// at a time; the back makes num_steps steps (num_steps is 1 with the ramp off), one step a
// cycle, stalling while the result queue is full. A request with a zero full scale is
// dropped in idle; one with no level change is dropped at hand-off.
// Reset: arst_n clears control state at once; registers return to 0, 20 and 1.
`default_nettype none

module brightness_ramp_generator #(
	parameter int MAX_STEPS = brg_pkg::MAX_STEPS_DEF,
	parameter int LEVEL_BITS = brg_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic signed [brg_pkg::PCT_W-1:0]    requested_percent,
	input  wire logic        [LEVEL_BITS-1:0]        current_level,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic             [LEVEL_BITS-1:0]        level,
	output logic                                     last,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic        [brg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [LEVEL_BITS-1:0]        cfg_data
);
	import brg_pkg::*;

	localparam int CMD_W = STEPS_W + 2 * LEVEL_BITS;

	logic [LEVEL_BITS-1:0] full_scale_q;
	logic [STEPS_W-1:0]    num_steps_q;
	logic                  ramp_enable_q;
	logic [STEPS_W-1:0]    steps_wr;

	logic                  f_cmd_push;
	logic                  cmd_full;
	cmd_ctl_t              f_cmd_ctl;
	logic [LEVEL_BITS-1:0] f_cmd_target;
	logic [LEVEL_BITS-1:0] f_cmd_cur;
	logic [CMD_W-1:0]      cmd_rd;
	logic                  cmd_empty;
	logic                  b_cmd_pop;
	logic                  out_push;
	logic                  out_full;
	logic [LEVEL_BITS-1:0] out_level;
	logic                  out_last;
	logic [LEVEL_BITS:0]   out_rd;

	assign cfg_ready = 1'b1;
	assign steps_wr  = cfg_data[STEPS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q  <= '0;
			num_steps_q   <= STEPS_W'(STEPS_RESET);
			ramp_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FULL_SCALE: begin
					full_scale_q <= cfg_data;
				end
				REG_NUM_STEPS: begin
					// ignore a step count outside 1..MAX_STEPS
					if (steps_wr != '0 && int'(steps_wr) <= MAX_STEPS) begin
						num_steps_q <= steps_wr;
					end
				end
				REG_RAMP_ENABLE: begin
					ramp_enable_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	brg_front #(
		.MAX_STEPS (MAX_STEPS),
		.LEVEL_BITS(LEVEL_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.requested_percent(requested_percent),
		.current_level    (current_level),
		.full_scale       (full_scale_q),
		.num_steps        (num_steps_q),
		.ramp_enable      (ramp_enable_q),
		.cmd_push         (f_cmd_push),
		.cmd_full         (cmd_full),
		.cmd_ctl          (f_cmd_ctl),
		.cmd_target       (f_cmd_target),
		.cmd_cur          (f_cmd_cur)
	);

	brg_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_cmd_push),
		.full   (cmd_full),
		.wr_data({f_cmd_ctl, f_cmd_target, f_cmd_cur}),
		.pop    (b_cmd_pop),
		.empty  (cmd_empty),
		.rd_data(cmd_rd)
	);

	brg_back #(
		.LEVEL_BITS(LEVEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (b_cmd_pop),
		.cmd_ctl   (cmd_ctl_t'(cmd_rd[CMD_W-1:2*LEVEL_BITS])),
		.cmd_target(cmd_rd[2*LEVEL_BITS-1:LEVEL_BITS]),
		.cmd_cur   (cmd_rd[LEVEL_BITS-1:0]),
		.out_push  (out_push),
		.out_full  (out_full),
		.out_level (out_level),
		.out_last  (out_last)
	);

	brg_fifo #(
		.WIDTH(LEVEL_BITS + 1),
		.DEPTH(QUEUE_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (out_full),
		.wr_data({out_level, out_last}),
		.pop    (pop),
		.empty  (empty),
		.rd_data(out_rd)
	);

	assign level = out_rd[LEVEL_BITS:1];
	assign last  = out_rd[0];

endmodule

`default_nettype wire

[tb/ramp_checker.sv]
`default_nettype none

module ramp_checker #(
	parameter int MAX_STEPS = brg_pkg::MAX_STEPS_DEF,
	parameter int LEVEL_BITS = brg_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	input  wire logic                                 full,
	input  wire logic signed [brg_pkg::PCT_W-1:0]     requested_percent,
	input  wire logic        [LEVEL_BITS-1:0]         current_level,
	input  wire logic                                 empty,
	input  wire logic                                 pop,
	input  wire logic        [LEVEL_BITS-1:0]         level,
	input  wire logic                                 last,
	input  wire logic                                 cfg_valid,
	input  wire logic                                 cfg_ready,
	input  wire logic        [brg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [LEVEL_BITS-1:0]         cfg_data,
	output int                                        errors,
	output int                                        outstanding
);
	import brg_pkg::*;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic                  last;
	} ramp_step_t;

	ramp_step_t ramp_steps_q[$];

	logic [LEVEL_BITS-1:0] full_scale = '0;
	logic [STEPS_W-1:0]    step_count = STEPS_W'(STEPS_RESET);
	logic                  ramp_on = 1'b1;

	int fail_count = 0;
	int pending_n = 0;

	assign errors = fail_count;
	assign outstanding = pending_n;

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("ramp_checker: %0t: %s", $time, what);
	endtask

	task automatic predict_ramp(input logic signed [PCT_W-1:0] pct_in,
			input logic [LEVEL_BITS-1:0] cur_in);
		longint pct_q;
		longint cur;
		longint target;
		longint diff;
		longint prev;
		longint n;
		longint k;
		longint v;
		if (full_scale == '0)
			return;
		pct_q = longint'(pct_in);
		if (pct_q > PCT_MAX)
			pct_q = PCT_MAX;
		if (pct_q < PCT_MIN)
			pct_q = PCT_MIN;
		cur = longint'(cur_in);
		// PCT_MAX is 100 % in Q8.8, so it is also the divisor
		target = (longint'(full_scale) * pct_q) / PCT_MAX;
		if (target == cur)
			return;
		if (!ramp_on) begin
			ramp_steps_q.push_back({LEVEL_BITS'(target), 1'b1});
			return;
		end
		n = longint'(step_count);
		diff = target - cur;
		prev = cur;
		for (k = 1; k <= n; k++) begin
			v = cur + (diff * k) / n;
			// drop steps that repeat the level before them
			if (v != prev) begin
				prev = v;
				ramp_steps_q.push_back({LEVEL_BITS'(v), k == n});
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ramp_step_t want;
		if (!arst_n) begin
			full_scale = '0;
			step_count = STEPS_W'(STEPS_RESET);
			ramp_on = 1'b1;
			ramp_steps_q.delete();
			pending_n <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FULL_SCALE: full_scale = cfg_data;
					REG_NUM_STEPS: begin
						// hold the old count on an out-of-range write
						if (cfg_data[STEPS_W-1:0] >= 1 && cfg_data[STEPS_W-1:0] <= MAX_STEPS)
							step_count = cfg_data[STEPS_W-1:0];
					end
					REG_RAMP_ENABLE: ramp_on = cfg_data[0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (ramp_steps_q.size() == 0) begin
					report_mismatch($sformatf("unexpected level %0d last %0d", level, last));
				end else begin
					want = ramp_steps_q.pop_front();
					if (level !== want.level)
						report_mismatch($sformatf("level got %0d want %0d", level, want.level));
					if (last !== want.last)
						report_mismatch($sformatf("last got %0d want %0d at level %0d",
							last, want.last, want.level));
				end
			end
			if (push && !full)
				predict_ramp(requested_percent, current_level);
			pending_n <= ramp_steps_q.size();
		end
	end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
	import brg_pkg::*;

	localparam int LB = LEVEL_BITS_DEF;
	localparam int MS = MAX_STEPS_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 120;
	localparam int PHASES = 11;
	localparam int PHASE_ITEMS = 30;
	localparam logic [LB-1:0] LEVEL_TOP = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [PCT_W-1:0] requested_percent = '0;
	logic [LB-1:0] current_level = '0;
	logic empty;
	logic pop = 1'b0;
	logic [LB-1:0] level;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LB-1:0] cfg_data = '0;

	int fail_total;
	int outstanding;
	bit calm_push = 1'b0;
	bit calm_pop = 1'b0;
	int cycle_count = 0;

	brightness_ramp_generator #(
		.MAX_STEPS(MS),
		.LEVEL_BITS(LB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.requested_percent(requested_percent),
		.current_level(current_level),
		.empty(empty),
		.pop(pop),
		.level(level),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ramp_checker #(
		.MAX_STEPS(MS),
		.LEVEL_BITS(LB)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.requested_percent(requested_percent),
		.current_level(current_level),
		.empty(empty),
		.pop(pop),
		.level(level),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(fail_total),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	task automatic send_request(input logic signed [PCT_W-1:0] pct, input logic [LB-1:0] cur);
		int gap;
		gap = calm_push ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		requested_percent <= pct;
		current_level <= cur;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LB-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off requests until every level has left, then let the front end drain
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [PCT_W-1:0] pick_percent();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return PCT_W'($urandom_range(PCT_MIN, PCT_MAX));
			5: return PCT_W'($urandom_range(PCT_MIN - 8, PCT_MIN + 8));
			6: return PCT_W'($urandom_range(PCT_MAX - 8, PCT_MAX + 8));
			7: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			default: return PCT_W'($urandom());
		endcase
	endfunction

	// steer the present level around the target so that short ramps and no-change cases occur
	function automatic logic [LB-1:0] pick_level(input logic [LB-1:0] mb,
			input logic signed [PCT_W-1:0] pct);
		longint p;
		longint t;
		p = longint'(pct);
		if (p > PCT_MAX)
			p = PCT_MAX;
		if (p < PCT_MIN)
			p = PCT_MIN;
		t = (longint'(mb) * p) / PCT_MAX;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return LEVEL_TOP;
			2: return LB'(t);
			3, 4: begin
				t = t + longint'($urandom_range(0, 80)) - 40;
				if (t < 0)
					t = 0;
				if (t > longint'(LEVEL_TOP))
					t = longint'(LEVEL_TOP);
				return LB'(t);
			end
			default: return LB'($urandom());
		endcase
	endfunction

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = calm_pop ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		logic [LB-1:0] mb;
		logic [LB-1:0] en_data;
		logic signed [PCT_W-1:0] pct;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// zero full scale after reset: no levels
		send_request(16'sd25600, '0);
		send_request(16'sh8000, LEVEL_TOP);
		settle();

		// unknown indexes and out-of-range step counts leave the registers alone
		write_reg(CFG_IDX_W'(3), LB'($urandom()));
		write_reg(8'hff, LEVEL_TOP);
		write_reg(REG_NUM_STEPS, LB'(0));
		write_reg(REG_NUM_STEPS, LB'(MS + 1));
		write_reg(REG_FULL_SCALE, LEVEL_TOP);
		send_request(16'sh7fff, '0);
		send_request(16'sh8000, LEVEL_TOP);
		send_request(16'sd0, LB'(12345));
		send_request(16'sd25601, '0);
		send_request(16'sd1279, '0);
		send_request(16'sd25600, LEVEL_TOP);
		send_request(16'sd1280, LB'(52428));
		send_request(16'sd12800, LB'(524288));
		send_request(16'sd12800, '0);
		settle();

		write_reg(REG_RAMP_ENABLE, LB'(0));
		send_request(16'sd25600, '0);
		send_request(16'sd128, LEVEL_TOP);
		settle();

		write_reg(REG_RAMP_ENABLE, LB'(1));
		write_reg(REG_NUM_STEPS, LB'(1));
		write_reg(REG_FULL_SCALE, LB'(1));
		send_request(16'sd25600, '0);
		send_request(16'sd1280, LB'(1));
		settle();

		write_reg(REG_NUM_STEPS, LB'(MS));
		send_request(16'sd25600, '0);
		send_request(16'sd1280, LB'(1));
		send_request(16'sd25600, LEVEL_TOP);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin mb = LEVEL_TOP; n = MS; en_data = LB'(1); end
				1: begin mb = LEVEL_TOP; n = 1; en_data = LB'(1); end
				2: begin mb = LB'(1); n = MS; en_data = LB'(1); end
				3: begin mb = LEVEL_TOP; n = MS; en_data = LB'(0); end
				4: begin mb = '0; n = $urandom_range(1, MS); en_data = LB'(1); end
				5: begin mb = LB'($urandom_range(1, 300)); n = $urandom_range(1, MS); en_data = LB'(1); end
				default: begin
					mb = ($urandom_range(0, 2) == 0) ? LB'($urandom_range(1, 2000)) : LB'($urandom());
					n = $urandom_range(1, MS);
					en_data = LB'($urandom());
					en_data[0] = ($urandom_range(0, 4) != 0);
				end
			endcase
			calm_push = (p % 4 == 1) || (p % 4 == 3);
			calm_pop = (p % 4 == 2) || (p % 4 == 3);

			write_reg(REG_FULL_SCALE, mb);
			// bits above the step field are dropped by the register
			write_reg(REG_NUM_STEPS, LB'(n + 32 * $urandom_range(0, 3)));
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_NUM_STEPS, ($urandom_range(0, 3) == 0) ? LB'(0)
					: LB'($urandom_range(MS + 1, 31)));
			write_reg(REG_RAMP_ENABLE, en_data);
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IDX_W'($urandom_range(3, 255)), LB'($urandom()));

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pct = pick_percent();
				send_request(pct, pick_level(mb, pct));
			end
			settle();
		end

		if (fail_total == 0 && outstanding == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
design/brg_pkg.sv
design/brg_fifo.sv
design/brg_div.sv
design/brg_front.sv
design/brg_back.sv
design/brightness_ramp_generator.sv
tb/ramp_checker.sv
tb/testbench.sv
